[hw/rtl/assert_macros.svh]
// Assertion macros shared by the particle store RTL.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSI_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PSI_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define PSI_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PSI_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

[hw/rtl/psi_pkg.sv]
// Shared types, constants and helper functions of the particle store.
// No dependencies.
`default_nettype none
package psi_pkg;

  localparam int CAPACITY   = 64;
  localparam int RING_COUNT = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int RING_W     = $clog2(RING_COUNT);
  localparam int CFG_W      = 17;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RING_W-1:0] ring_idx_t;

  typedef enum logic [2:0] {
    CMD_SPAWN  = 3'd0,
    CMD_RING   = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_RENDER = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_RING_SPEED = 2'd0,
    CFG_RING_LIFE  = 2'd1,
    CFG_RING_SIZE  = 2'd2
  } cfg_index_t;

  localparam logic [14:0] RING_SPEED_RST = 15'd1440;
  localparam logic [16:0] RING_LIFE_RST  = 17'd29491;
  localparam logic [7:0]  RING_SIZE_RST  = 8'd48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_RING_MUL,
    ST_RING_WR,
    ST_TICK_RD,
    ST_TICK_MUL1,
    ST_TICK_ADD,
    ST_TICK_MUL2,
    ST_TICK_WR,
    ST_REN_RD,
    ST_REN_MUL,
    ST_REN_START,
    ST_REN_DIV,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [16:0]        remaining;
    logic [16:0]        full_life;
    logic [11:0]        gravity;
    logic [7:0]         size;
    logic [31:0]        color;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Quarter wave of sine, 1/16384 units, 1/64 turn steps.
  function automatic logic [14:0] quarter_sine(input logic [4:0] r);
    case (r)
      5'd0:    return 15'd0;
      5'd1:    return 15'd1606;
      5'd2:    return 15'd3196;
      5'd3:    return 15'd4756;
      5'd4:    return 15'd6270;
      5'd5:    return 15'd7723;
      5'd6:    return 15'd9102;
      5'd7:    return 15'd10394;
      5'd8:    return 15'd11585;
      5'd9:    return 15'd12665;
      5'd10:   return 15'd13623;
      5'd11:   return 15'd14449;
      5'd12:   return 15'd15137;
      5'd13:   return 15'd15678;
      5'd14:   return 15'd16069;
      5'd15:   return 15'd16305;
      5'd16:   return 15'd16384;
      default: return 15'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sine_of(input logic [5:0] phase);
    logic [14:0] m;
    if (phase[4]) begin
      m = quarter_sine(5'd16 - {1'b0, phase[3:0]});
    end else begin
      m = quarter_sine({1'b0, phase[3:0]});
    end
    return phase[5] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Angle of ring particle i, nearest 1/64 turn.
  function automatic logic [5:0] ring_phase(input ring_idx_t i);
    return 6'((int'(i) * 64 + RING_COUNT / 2) / RING_COUNT);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/psi_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module psi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/psi_alpha_div.sv]
// Alpha scaler: floor(num / den) clamped to 255, zero for a zero divisor.
// Restoring division, one quotient bit per cycle; uses nothing from the package.
`default_nettype none
module psi_alpha_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [24:0] num,
  input  wire logic [16:0] den,
  output logic             done,
  output logic [7:0]       quo
);

  logic        active;
  logic [3:0]  step;
  logic [16:0] rem;
  logic [7:0]  nsh;
  logic [7:0]  q;
  logic [16:0] dv;
  logic [17:0] trial;
  logic        qbit;

  assign trial = {rem, nsh[7]};
  assign qbit  = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dv <= den;
        if (den == 17'd0) begin
          quo  <= 8'd0;
          done <= 1'b1;
        end else if (num >= {den, 8'd0}) begin
          quo  <= 8'hff;
          done <= 1'b1;
        end else begin
          // high part is already below the divisor
          rem    <= num[24:8];
          nsh    <= num[7:0];
          step   <= 4'd8;
          active <= 1'b1;
        end
      end else if (active) begin
        rem  <= qbit ? 17'(trial - {1'b0, dv}) : trial[16:0];
        nsh  <= {nsh[6:0], 1'b0};
        q    <= {q[6:0], qbit};
        step <= step - 4'd1;
        if (step == 4'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
          quo    <= {q[6:0], qbit};
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/particle_store_integrator_unit.sv]
// Particle store with Euler update; one command at a time, busy while working.
// Ring: multiply, write per particle. Tick: read, multiply, add, multiply, write per
// held particle. Render: read, multiply, start, eight-step alpha divide per quad.
// Spawn, ring and tick end in status, as do clear, unknown codes, empty tick/render.
// Next command is taken in the cycle the final result is shown; results cannot stall.
// Synchronous active-high reset clears the count and the FSM and loads the ring registers
// with their defaults; particle RAM contents are not cleared, only entries below the count are read.
`default_nettype none
`include "assert_macros.svh"
module particle_store_integrator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic [16:0]        life,
  input  wire logic [11:0]        fall_rate,
  input  wire logic [7:0]         quad_size,
  input  wire logic [31:0]        color,
  input  wire logic [15:0]        tick_length,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [psi_pkg::CFG_W-1:0] wr_data,
  output logic                    strobe,
  output logic                    quad_valid,
  output logic signed [15:0]      left,
  output logic signed [15:0]      top,
  output logic [7:0]              side,
  output logic [23:0]             rgb,
  output logic [7:0]              alpha,
  output logic [6:0]              live_count,
  output logic                    dropped,
  output logic                    last
);

  psi_pkg::state_t state, state_next;

  // ring configuration
  logic [14:0] ring_speed;
  logic [16:0] ring_life;
  logic [7:0]  ring_size;

  // latched command item
  logic [2:0]         cmd_q;
  logic signed [15:0] in_x, in_y, in_vx, in_vy;
  logic [16:0]        in_life;
  logic [11:0]        in_grav;
  logic [7:0]         in_size;
  logic [31:0]        in_color;
  logic [15:0]        dt_q;
  logic               drop_q;

  psi_pkg::count_t    count;
  psi_pkg::count_t    idx;      // read walker for tick and render
  psi_pkg::count_t    wr_idx;   // compaction write pointer
  psi_pkg::ring_idx_t ring_idx;

  // datapath registers
  psi_pkg::entry_t    ent;
  logic signed [31:0] prod_c, prod_s;
  logic [27:0]        p_g;
  logic signed [32:0] p_vx, p_vy;
  logic signed [15:0] vy_new, x_new;
  logic [24:0]        num_q;

  // RAM ports
  logic               mem_we, mem_re;
  psi_pkg::idx_t      mem_waddr, mem_raddr;
  psi_pkg::entry_t    mem_wdata, mem_rdata;

  logic               div_start, div_done;
  logic [7:0]         div_quo;

  logic               room;
  logic               idx_last;
  logic               ring_last;
  logic               keep;
  logic [5:0]         ph;
  logic signed [15:0] cos_v, sin_v;
  logic signed [15:0] y_new;
  logic [7:0]         half;

  assign busy      = (state != psi_pkg::ST_IDLE);
  assign room      = (count < psi_pkg::count_t'(psi_pkg::CAPACITY));
  assign idx_last  = (psi_pkg::count_t'(idx + 1'b1) == count);
  assign ring_last = (ring_idx == psi_pkg::ring_idx_t'(psi_pkg::RING_COUNT - 1));
  assign keep      = (ent.remaining > {1'b0, dt_q});
  assign ph        = psi_pkg::ring_phase(ring_idx);
  assign cos_v     = psi_pkg::sine_of(ph + 6'd16);
  assign sin_v     = psi_pkg::sine_of(ph);
  assign y_new     = psi_pkg::sat16(18'(ent.y) + 18'(p_vy >>> 16));
  assign half      = 8'(({1'b0, ent.size} + 9'd1) >> 1);
  assign live_count = 7'(count);
  assign div_start = (state == psi_pkg::ST_REN_START);

  psi_ram #(
    .WIDTH(psi_pkg::ENTRY_W),
    .DEPTH(psi_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  psi_alpha_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_q),
    .den  (ent.full_life),
    .done (div_done),
    .quo  (div_quo)
  );

  // RAM access: appends write at the count, tick writes at the compaction pointer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[psi_pkg::IDX_W-1:0];
    mem_wdata = ent;
    mem_re    = (state == psi_pkg::ST_TICK_RD) || (state == psi_pkg::ST_REN_RD);
    mem_raddr = idx[psi_pkg::IDX_W-1:0];
    case (state)
      psi_pkg::ST_SPAWN: begin
        mem_we    = room;
        mem_wdata = '{x: in_x, y: in_y, vx: in_vx, vy: in_vy, remaining: in_life,
                      full_life: in_life, gravity: in_grav, size: in_size,
                      color: in_color};
      end
      psi_pkg::ST_RING_WR: begin
        mem_we    = room;
        mem_wdata = '{x: in_x, y: in_y,
                      vx: psi_pkg::sat16(18'(prod_c >>> 14)),
                      vy: psi_pkg::sat16(18'(prod_s >>> 14)),
                      remaining: ring_life, full_life: ring_life, gravity: 12'd0,
                      size: ring_size, color: in_color};
      end
      psi_pkg::ST_TICK_WR: begin
        mem_we    = keep;
        mem_waddr = wr_idx[psi_pkg::IDX_W-1:0];
        mem_wdata = '{x: x_new, y: y_new, vx: ent.vx, vy: vy_new,
                      remaining: 17'(ent.remaining - {1'b0, dt_q}),
                      full_life: ent.full_life, gravity: ent.gravity,
                      size: ent.size, color: ent.color};
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psi_pkg::ST_IDLE: begin
        if (start) begin
          case (command)
            psi_pkg::CMD_SPAWN:  state_next = psi_pkg::ST_SPAWN;
            psi_pkg::CMD_RING:   state_next = psi_pkg::ST_RING_MUL;
            psi_pkg::CMD_TICK:
              state_next = (count == '0) ? psi_pkg::ST_STATUS : psi_pkg::ST_TICK_RD;
            psi_pkg::CMD_RENDER:
              state_next = (count == '0) ? psi_pkg::ST_STATUS : psi_pkg::ST_REN_RD;
            default:             state_next = psi_pkg::ST_STATUS;
          endcase
        end
      end
      psi_pkg::ST_SPAWN:     state_next = psi_pkg::ST_STATUS;
      psi_pkg::ST_RING_MUL:  state_next = psi_pkg::ST_RING_WR;
      psi_pkg::ST_RING_WR:
        state_next = ring_last ? psi_pkg::ST_STATUS : psi_pkg::ST_RING_MUL;
      psi_pkg::ST_TICK_RD:   state_next = psi_pkg::ST_TICK_MUL1;
      psi_pkg::ST_TICK_MUL1: state_next = psi_pkg::ST_TICK_ADD;
      psi_pkg::ST_TICK_ADD:  state_next = psi_pkg::ST_TICK_MUL2;
      psi_pkg::ST_TICK_MUL2: state_next = psi_pkg::ST_TICK_WR;
      psi_pkg::ST_TICK_WR:
        state_next = idx_last ? psi_pkg::ST_STATUS : psi_pkg::ST_TICK_RD;
      psi_pkg::ST_REN_RD:    state_next = psi_pkg::ST_REN_MUL;
      psi_pkg::ST_REN_MUL:   state_next = psi_pkg::ST_REN_START;
      psi_pkg::ST_REN_START: state_next = psi_pkg::ST_REN_DIV;
      psi_pkg::ST_REN_DIV: begin
        if (div_done) begin
          state_next = idx_last ? psi_pkg::ST_IDLE : psi_pkg::ST_REN_RD;
        end
      end
      psi_pkg::ST_STATUS:    state_next = psi_pkg::ST_IDLE;
      default:               state_next = psi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers: to be written only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_speed <= psi_pkg::RING_SPEED_RST;
      ring_life  <= psi_pkg::RING_LIFE_RST;
      ring_size  <= psi_pkg::RING_SIZE_RST;
    end else if (wr_en) begin
      case (wr_index)
        psi_pkg::CFG_RING_SPEED: ring_speed <= wr_data[14:0];
        psi_pkg::CFG_RING_LIFE:  ring_life  <= wr_data[16:0];
        psi_pkg::CFG_RING_SIZE:  ring_size  <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // control: count, walkers, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      wr_idx   <= '0;
      ring_idx <= '0;
      drop_q   <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        psi_pkg::ST_IDLE: begin
          if (start) begin
            idx      <= '0;
            wr_idx   <= '0;
            ring_idx <= '0;
            drop_q   <= 1'b0;
            if (command == psi_pkg::CMD_CLEAR) begin
              count <= '0;
            end
          end
        end
        psi_pkg::ST_SPAWN, psi_pkg::ST_RING_WR: begin
          // append if there is room, otherwise drop and flag
          if (room) begin
            count <= psi_pkg::count_t'(count + 1'b1);
          end else begin
            drop_q <= 1'b1;
          end
          ring_idx <= psi_pkg::ring_idx_t'(ring_idx + 1'b1);
        end
        psi_pkg::ST_TICK_WR: begin
          if (keep) begin
            wr_idx <= psi_pkg::count_t'(wr_idx + 1'b1);
          end
          idx <= psi_pkg::count_t'(idx + 1'b1);
          if (idx_last) begin
            count <= psi_pkg::count_t'(wr_idx + psi_pkg::count_t'(keep));
          end
        end
        psi_pkg::ST_REN_DIV: begin
          if (div_done) begin
            strobe <= 1'b1;
            idx    <= psi_pkg::count_t'(idx + 1'b1);
          end
        end
        psi_pkg::ST_STATUS: begin
          strobe <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload: item latch, arithmetic stages, result fields
  always_ff @(posedge clk) begin
    case (state)
      psi_pkg::ST_IDLE: begin
        if (start) begin
          cmd_q    <= command;
          in_x     <= pos_x;
          in_y     <= pos_y;
          in_vx    <= vel_x;
          in_vy    <= vel_y;
          in_life  <= life;
          in_grav  <= fall_rate;
          in_size  <= quad_size;
          in_color <= color;
          dt_q     <= tick_length;
        end
      end
      psi_pkg::ST_RING_MUL: begin
        prod_c <= $signed({1'b0, ring_speed}) * cos_v;
        prod_s <= $signed({1'b0, ring_speed}) * sin_v;
      end
      psi_pkg::ST_TICK_MUL1: begin
        ent  <= mem_rdata;
        p_g  <= mem_rdata.gravity * dt_q;
        p_vx <= mem_rdata.vx * $signed({1'b0, dt_q});
      end
      psi_pkg::ST_TICK_ADD: begin
        // gravity first; y then uses the updated velocity
        vy_new <= psi_pkg::sat16(18'(ent.vy) + 18'($signed({1'b0, p_g[27:16]})));
        x_new  <= psi_pkg::sat16(18'(ent.x) + 18'(p_vx >>> 16));
      end
      psi_pkg::ST_TICK_MUL2: begin
        p_vy <= vy_new * $signed({1'b0, dt_q});
      end
      psi_pkg::ST_REN_MUL: begin
        ent   <= mem_rdata;
        num_q <= mem_rdata.color[7:0] * mem_rdata.remaining;
      end
      psi_pkg::ST_REN_DIV: begin
        if (div_done) begin
          quad_valid <= 1'b1;
          left       <= psi_pkg::sat16(18'(ent.x) - 18'($signed({1'b0, half})));
          top        <= psi_pkg::sat16(18'(ent.y) - 18'($signed({1'b0, half})));
          side       <= ent.size;
          rgb        <= ent.color[31:8];
          alpha      <= div_quo;
          dropped    <= 1'b0;
          last       <= idx_last;
        end
      end
      psi_pkg::ST_STATUS: begin
        quad_valid <= 1'b0;
        left       <= '0;
        top        <= '0;
        side       <= '0;
        rgb        <= '0;
        alpha      <= '0;
        dropped    <= drop_q && ((cmd_q == psi_pkg::CMD_SPAWN) ||
                                 (cmd_q == psi_pkg::CMD_RING));
        last       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `PSI_ASSERT_ALWAYS(a_count_cap, count <= psi_pkg::count_t'(psi_pkg::CAPACITY), "count high")
  `PSI_ASSERT_IMPLY(a_last_idle, strobe && last, !busy, "final item while still busy")
  `PSI_ASSERT_IMPLY(a_tick_order, state == psi_pkg::ST_TICK_WR, wr_idx <= idx, "write ahead")
  `PSI_ASSERT_IMPLY(a_drop_status, strobe && dropped, !quad_valid && last, "drop flag on a quad")
  `PSI_ASSERT_IMPLY(a_render_div, strobe && quad_valid, $past(div_done), "quad without alpha")

endmodule
`default_nettype wire
